### src/load_cell_window_average_stability_defines.svh
// ---------------------------------------------------------------------------
// load cell window average assertion macros
// concurrent assertion helpers shared by the rtl, compiled out with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef LOAD_CELL_WINDOW_AVERAGE_STABILITY_DEFINES_SVH
`define LOAD_CELL_WINDOW_AVERAGE_STABILITY_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define LCWAS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcwas assertion failed");
// next-cycle implication
`define LCWAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcwas assertion failed");
`else
`define LCWAS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LCWAS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### src/lcwas_pkg.sv
// ---------------------------------------------------------------------------
// lcwas_pkg
// types and constants of the load cell window average block
// ---------------------------------------------------------------------------
package lcwas_pkg;

  localparam int WINDOW_DEPTH_DEFAULT = 8;
  localparam int SAMPLE_BITS = 20;
  localparam int TOL_BITS = 16;
  localparam int FILL_BITS = 7;

  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd16;
  // -1.5 g in 1/16 g
  localparam logic signed [SAMPLE_BITS-1:0] DEAD_ZONE_LIMIT = -20'sd24;

  typedef struct packed {
    logic                          req_type;
    logic signed [SAMPLE_BITS-1:0] sample_weight;
  } sample_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] current_weight;
    logic signed [SAMPLE_BITS-1:0] filtered_weight;
    logic                          is_stable;
    logic [FILL_BITS-1:0]          fill_count;
  } result_word_t;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

### src/lcwas_divider.sv
// ---------------------------------------------------------------------------
// lcwas_divider
// restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module lcwas_divider #(
  parameter int DIVIDEND_W = lcwas_pkg::SAMPLE_BITS + 3,
  parameter int DIVISOR_W  = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

### src/load_cell_window_average_stability.sv
// ---------------------------------------------------------------------------
// load_cell_window_average_stability
// ring window of weight samples with truncated mean and stability flag
// ---------------------------------------------------------------------------
// each sample word is dead-zone clamped (-23..-1 in 1/16 g become zero),
// written into a ring window of WINDOW_DEPTH entries, and answered with one
// result word: the clamped sample, the mean of the filled entries truncated
// toward zero, a stable flag (window full and max minus min within the
// tolerance register) and the fill count. a clear word (tare) empties the
// window and answers with all zeros. a sample word walks the window memory
// one registered read per cycle over the filled entries, then runs the
// 23-bit sum (at the default depth of 8) through the serial divider one
// quotient bit per cycle, and then loads the result register. the next
// word is taken once the block is back in idle after the result is loaded,
// so a sample word is not accepted until the last one is through. a clear
// word skips the walk and the divider and goes straight to the finish state
// that loads the result register. sample_stall is high while a word is worked;
// the result register lets the next word be accepted while a result waits
// on result_stall, and a finished word waits only while the result register
// is still full and stalled. the tolerance register is written with
// cfg_write_en and resets to 16.
// ---------------------------------------------------------------------------
`include "load_cell_window_average_stability_defines.svh"

module load_cell_window_average_stability #(
  parameter int WINDOW_DEPTH = lcwas_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // sample channel
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  lcwas_pkg::sample_word_t           sample_word,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output lcwas_pkg::result_word_t           result_word,
  // tolerance register write
  input  logic                              cfg_write_en,
  input  logic [lcwas_pkg::TOL_BITS-1:0]    cfg_write_data
);

  localparam int SB       = lcwas_pkg::SAMPLE_BITS;
  localparam int IDX_W    = $clog2(WINDOW_DEPTH);
  localparam int COUNT_W  = $clog2(WINDOW_DEPTH + 1);
  // exact window sum, signed
  localparam int SUM_W    = SB + IDX_W;
  localparam int SPREAD_W = SB + 1;
  // fill count of a full window as carried in the result word
  localparam logic [lcwas_pkg::FILL_BITS-1:0] FILL_FULL = lcwas_pkg::FILL_BITS'(WINDOW_DEPTH);

  // sequencer
  lcwas_pkg::state_t state, state_next;

  // configuration
  logic [lcwas_pkg::TOL_BITS-1:0] tolerance;

  // window bookkeeping
  logic [IDX_W-1:0]   write_slot;
  logic [COUNT_W-1:0] fill;
  logic               clear_item;
  logic signed [SB-1:0] cur_weight;
  logic signed [SB-1:0] clamped;

  // window memory and walk
  logic signed [SB-1:0] window_mem [WINDOW_DEPTH];
  logic signed [SB-1:0] rd_data;
  logic                 rd_valid;
  logic [COUNT_W-1:0]   rd_cnt;
  logic signed [SUM_W-1:0] sum;
  logic signed [SB-1:0] lo;
  logic signed [SB-1:0] hi;

  // sequencer outputs
  logic accept;
  logic issue;
  logic walk_done;
  logic div_start;
  logic load_result;

  // divider
  logic             sum_neg;
  logic [SUM_W-1:0] sum_mag;
  logic [SUM_W-1:0] quo;
  logic [SUM_W-1:0] mean_full;
  logic             div_done;
  logic [SPREAD_W-1:0] spread;
  logic             stable;

  // ---------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      lcwas_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (sample_word.req_type == lcwas_pkg::REQ_CLEAR) ?
                       lcwas_pkg::ST_FINISH : lcwas_pkg::ST_WALK;
        end
      end
      lcwas_pkg::ST_WALK: begin
        if (walk_done) state_next = lcwas_pkg::ST_DIV;
      end
      lcwas_pkg::ST_DIV: begin
        if (div_done) state_next = lcwas_pkg::ST_FINISH;
      end
      lcwas_pkg::ST_FINISH: begin
        if (!result_valid || !result_stall) state_next = lcwas_pkg::ST_IDLE;
      end
      default: state_next = lcwas_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // sequencer outputs
  // ---------------------------------------------------------------------
  always_comb begin
    sample_stall = 1'b1;
    issue        = 1'b0;
    walk_done    = 1'b0;
    div_start    = 1'b0;
    load_result  = 1'b0;
    unique case (state)
      lcwas_pkg::ST_IDLE: begin
        sample_stall = 1'b0;
      end
      lcwas_pkg::ST_WALK: begin
        // one window read per cycle over the filled entries
        issue     = (rd_cnt != fill);
        walk_done = (rd_cnt == fill) && !rd_valid;
        div_start = walk_done;
      end
      lcwas_pkg::ST_DIV: begin
      end
      lcwas_pkg::ST_FINISH: begin
        // result register free or emptying this cycle
        load_result = !result_valid || !result_stall;
      end
      default: begin
      end
    endcase
  end

  assign accept = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) state <= lcwas_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst)               tolerance <= lcwas_pkg::TOL_RESET;
    else if (cfg_write_en) tolerance <= cfg_write_data;
  end

  // dead zone: just below zero down to but not including -1.5 g
  always_comb begin
    clamped = sample_word.sample_weight;
    if (sample_word.sample_weight < 0 &&
        sample_word.sample_weight > lcwas_pkg::DEAD_ZONE_LIMIT) begin
      clamped = '0;
    end
  end

  // ---------------------------------------------------------------------
  // window pointer and fill count
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill       <= '0;
    end else if (accept) begin
      if (sample_word.req_type == lcwas_pkg::REQ_CLEAR) begin
        write_slot <= '0;
        fill       <= '0;
      end else begin
        write_slot <= (write_slot == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : write_slot + 1'b1;
        if (fill != COUNT_W'(WINDOW_DEPTH)) fill <= fill + 1'b1;
      end
    end
  end

  // item payload captured on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      clear_item <= (sample_word.req_type == lcwas_pkg::REQ_CLEAR);
      cur_weight <= clamped;
    end
  end

  // ---------------------------------------------------------------------
  // window memory: one write on a sample accept, one registered read per walk step
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept && sample_word.req_type == lcwas_pkg::REQ_SAMPLE) begin
      window_mem[write_slot] <= clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) rd_data <= window_mem[rd_cnt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      rd_cnt   <= '0;
    end else begin
      rd_valid <= issue;
      if (accept)     rd_cnt <= '0;
      else if (issue) rd_cnt <= rd_cnt + 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // sum, min and max accumulate as the reads come back
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      // start from the extremes so the first entry wins both compares
      sum <= '0;
      lo  <= {1'b0, {(SB-1){1'b1}}};
      hi  <= {1'b1, {(SB-1){1'b0}}};
    end else if (rd_valid) begin
      sum <= sum + {{(SUM_W-SB){rd_data[SB-1]}}, rd_data};
      if (rd_data < lo) lo <= rd_data;
      if (rd_data > hi) hi <= rd_data;
    end
  end

  // ---------------------------------------------------------------------
  // mean: magnitude of the sum through the serial divider, sign restored
  // so the quotient truncates toward zero
  // ---------------------------------------------------------------------
  assign sum_neg = sum[SUM_W-1];
  assign sum_mag = sum_neg ? (~sum + 1'b1) : sum;

  lcwas_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (COUNT_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (fill),
    .done     (div_done),
    .quotient (quo)
  );

  assign mean_full = sum_neg ? (~quo + 1'b1) : quo;

  // spread is never negative once the window holds a sample
  assign spread = {hi[SB-1], hi} - {lo[SB-1], lo};
  assign stable = (fill == COUNT_W'(WINDOW_DEPTH)) &&
                  (spread <= SPREAD_W'(tolerance));

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      if (clear_item) begin
        result_word <= '0;
      end else begin
        result_word.current_weight  <= cur_weight;
        result_word.filtered_weight <= mean_full[SB-1:0];
        result_word.is_stable       <= stable;
        result_word.fill_count      <= lcwas_pkg::FILL_BITS'(fill);
      end
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `LCWAS_ASSERT_IMPLY(a_fill_bound, clk, rst, 1'b1, fill <= COUNT_W'(WINDOW_DEPTH))
  `LCWAS_ASSERT_NEXT(a_accept_busy, clk, rst, accept, state != lcwas_pkg::ST_IDLE)
  `LCWAS_ASSERT_IMPLY(a_stable_full, clk, rst, result_word.is_stable, result_word.fill_count == FILL_FULL)

endmodule
